FILE: src/ll1pp_pkg.sv
package ll1pp_pkg;

    // Input commands.
    localparam logic [2:0] CMD_TABLE_WR = 3'd0;
    localparam logic [2:0] CMD_PROD_WR  = 3'd1;
    localparam logic [2:0] CMD_START    = 3'd2;
    localparam logic [2:0] CMD_TOKEN    = 3'd3;
    localparam logic [2:0] CMD_END      = 3'd4;

    // Result kinds.
    localparam logic [2:0] KIND_EXPAND   = 3'd0;
    localparam logic [2:0] KIND_MATCH    = 3'd1;
    localparam logic [2:0] KIND_ACCEPT   = 3'd2;
    localparam logic [2:0] KIND_MISS     = 3'd3;
    localparam logic [2:0] KIND_MISMATCH = 3'd4;
    localparam logic [2:0] KIND_TRAILING = 3'd5;
    localparam logic [2:0] KIND_LIMIT    = 3'd6;

    // Configuration register indexes.
    localparam logic CFG_START_SYMBOL = 1'b0;
    localparam logic CFG_END_COLUMN   = 1'b1;

    // Largest number of results one word may produce before the limit error.
    localparam logic [5:0] RESULT_LIMIT = 6'd63;

    // Symbol stored in a right side to mark an epsilon production.
    localparam logic [7:0] EPSILON_SYMBOL = 8'hFF;

    // One result word.
    typedef struct packed {
        logic [2:0] kind;
        logic [6:0] production;
        logic [6:0] symbol;
        logic       last;
    } result_t;

endpackage

FILE: src/ll1pp_ram.sv
module ll1pp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port; read data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/ll1_predictive_parser.sv
// Channel   Direction  Handshake              Contents
// input     in         in_valid / in_stall    cmd, table and production fields, token
// output    out        out_valid / out_stall  kind, production, symbol, last
// config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A token or end word walks the stack: the top is read and tested, each
// expansion reads the table and the length, and each pushed symbol is written,
// in turn, as the stack, table and production memories each have one read port.
// Reset clears the state, stack pointer, failed flag, counters and valid flag
// and presets the start symbol and end column; the memories need no clearing.
// A stalled result holds the walk in place until it is taken.
module ll1_predictive_parser
    import ll1pp_pkg::*;
#(
    parameter int TERMINALS    = 38,
    parameter int NONTERMINALS = 64,
    parameter int PRODUCTIONS  = 128,
    parameter int MAX_RHS      = 8,
    parameter int STACK_DEPTH  = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] cmd,
    input  logic [5:0] table_row,
    input  logic [5:0] table_col,
    input  logic signed [7:0] table_entry,
    input  logic [6:0] prod_index,
    input  logic [2:0] prod_pos,
    input  logic signed [7:0] prod_symbol,
    input  logic [3:0] prod_length,
    input  logic [5:0] token_type,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] kind,
    output logic [6:0] production,
    output logic [6:0] symbol,
    output logic       last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [6:0] cfg_data
);

    localparam int TDEPTH = NONTERMINALS * TERMINALS;
    localparam int TAW    = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
    localparam int SDEPTH = PRODUCTIONS * MAX_RHS;
    localparam int SAW    = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
    localparam int PAW    = (PRODUCTIONS > 1) ? $clog2(PRODUCTIONS) : 1;
    localparam int KAW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SPW    = $clog2(STACK_DEPTH + 1);
    localparam int CW     = $clog2(MAX_RHS + 1);

    typedef enum logic [2:0] {S_IDLE, S_TOP, S_HAVE, S_TBL, S_LEN, S_PUSH} state_t;

    state_t           state_reg;
    logic [SPW-1:0]   sp_reg;
    logic             failed_reg;
    logic [5:0]       n_reg;
    logic [CW-1:0]    cnt_reg;
    logic [7:0]       entry_reg;
    logic [5:0]       col_reg;
    logic [5:0]       tok_reg;
    logic             is_end_reg;
    logic [6:0]       start_reg;
    logic [5:0]       endcol_reg;
    logic             ov_reg;
    result_t          res_reg;

    // Memory ports.
    logic             tbl_we, tbl_re;
    logic [TAW-1:0]   tbl_waddr, tbl_raddr;
    logic [7:0]       tbl_rd;
    logic             sym_we, sym_re;
    logic [SAW-1:0]   sym_waddr, sym_raddr;
    logic [7:0]       sym_rd;
    logic             len_we, len_re;
    logic [PAW-1:0]   len_waddr;
    logic [3:0]       len_rd;
    logic             stk_we, stk_re;
    logic [KAW-1:0]   stk_waddr, stk_raddr;
    logic [6:0]       stk_wdata, stk_rd;

    // Walk decode.
    logic             slot_free;
    logic             in_acc;
    logic [SPW-1:0]   sp_dec;
    logic [8:0]       top_ext;
    logic [6:0]       row;
    logic             top_is_term;
    logic             lookup_bad;
    logic             entry_bad;
    logic [CW-1:0]    len_eff;
    logic             overflow;
    logic [SAW-1:0]   rhs_base;
    logic [CW-1:0]    cnt_dec;
    logic             ov_set;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign slot_free = !ov_reg || !out_stall;

    assign sp_dec      = sp_reg - SPW'(1);
    assign top_ext     = {2'b00, stk_rd};
    assign row         = stk_rd - 7'(TERMINALS);
    assign top_is_term = top_ext < 9'(TERMINALS);
    assign lookup_bad  = (top_ext >= 9'(TERMINALS + NONTERMINALS))
                         || ({1'b0, col_reg} >= 7'(TERMINALS));
    assign entry_bad   = tbl_rd[7] || ({1'b0, tbl_rd} >= 9'(PRODUCTIONS));
    assign rhs_base    = SAW'(entry_reg) * SAW'(MAX_RHS);
    assign cnt_dec     = cnt_reg - CW'(1);

    // Effective right-side length: clamp to the maximum, epsilon marker gives zero.
    always_comb
    begin
        if (sym_rd == EPSILON_SYMBOL)
        begin
            len_eff = '0;
        end
        else if ({1'b0, len_rd} > 5'(MAX_RHS))
        begin
            len_eff = CW'(MAX_RHS);
        end
        else
        begin
            len_eff = CW'(len_rd);
        end
    end

    assign overflow = ({1'b0, sp_dec} + (SPW + 1)'(len_eff)) > (SPW + 1)'(STACK_DEPTH);

    // A new result word enters the output register in this cycle.
    always_comb
    begin
        unique case (state_reg)
            S_TOP:
            begin
                ov_set = slot_free && (sp_reg == '0);
            end
            S_HAVE:
            begin
                ov_set = slot_free && (top_is_term || (n_reg == RESULT_LIMIT) || lookup_bad);
            end
            S_TBL:
            begin
                ov_set = slot_free && entry_bad;
            end
            S_LEN:
            begin
                ov_set = slot_free;
            end
            default:
            begin
                ov_set = 1'b0;
            end
        endcase
    end

    // Memory addressing and enables.
    always_comb
    begin
        tbl_we    = in_acc && (cmd == CMD_TABLE_WR)
                    && ({1'b0, table_row} < 7'(NONTERMINALS))
                    && ({1'b0, table_col} < 7'(TERMINALS));
        tbl_waddr = TAW'(table_row) * TAW'(TERMINALS) + TAW'(table_col);
        tbl_re    = (state_reg == S_HAVE) && !top_is_term && (n_reg != RESULT_LIMIT)
                    && !lookup_bad;
        tbl_raddr = TAW'(row) * TAW'(TERMINALS) + TAW'(col_reg);

        sym_we    = in_acc && (cmd == CMD_PROD_WR)
                    && ({1'b0, prod_index} < 8'(PRODUCTIONS))
                    && ({1'b0, prod_pos} < 5'(MAX_RHS));
        sym_waddr = SAW'(prod_index) * SAW'(MAX_RHS) + SAW'(prod_pos);
        len_we    = sym_we;
        len_waddr = PAW'(prod_index);
        len_re    = (state_reg == S_TBL) && !entry_bad;

        sym_re    = 1'b0;
        sym_raddr = SAW'(tbl_rd) * SAW'(MAX_RHS);
        unique case (state_reg)
            S_TBL:
            begin
                sym_re = !entry_bad;
            end
            S_LEN:
            begin
                sym_re    = slot_free && !overflow && (len_eff != '0);
                sym_raddr = rhs_base + SAW'(len_eff - CW'(1));
            end
            S_PUSH:
            begin
                sym_re    = (cnt_dec != '0);
                sym_raddr = rhs_base + SAW'(cnt_dec - CW'(1));
            end
            default:
            begin
                sym_re = 1'b0;
            end
        endcase

        stk_re    = (state_reg == S_TOP) && (sp_reg != '0);
        stk_raddr = sp_dec[KAW-1:0];
        if (state_reg == S_PUSH)
        begin
            stk_we    = 1'b1;
            stk_waddr = sp_reg[KAW-1:0];
            stk_wdata = sym_rd[6:0];
        end
        else
        begin
            stk_we    = in_acc && (cmd == CMD_START);
            stk_waddr = '0;
            stk_wdata = start_reg;
        end
    end

    ll1pp_ram #(.WIDTH(8), .DEPTH(TDEPTH)) u_table (
        .clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(table_entry),
        .re(tbl_re), .raddr(tbl_raddr), .rdata(tbl_rd)
    );

    ll1pp_ram #(.WIDTH(8), .DEPTH(SDEPTH)) u_symbols (
        .clk(clk), .we(sym_we), .waddr(sym_waddr), .wdata(prod_symbol),
        .re(sym_re), .raddr(sym_raddr), .rdata(sym_rd)
    );

    ll1pp_ram #(.WIDTH(4), .DEPTH(PRODUCTIONS)) u_lengths (
        .clk(clk), .we(len_we), .waddr(len_waddr), .wdata(prod_length),
        .re(len_re), .raddr(tbl_rd[PAW-1:0]), .rdata(len_rd)
    );

    ll1pp_ram #(.WIDTH(7), .DEPTH(STACK_DEPTH)) u_stack (
        .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .re(stk_re), .raddr(stk_raddr), .rdata(stk_rd)
    );

    // Control sequencer and output word register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            sp_reg     <= '0;
            failed_reg <= 1'b0;
            n_reg      <= '0;
            cnt_reg    <= '0;
            start_reg  <= 7'd38;
            endcol_reg <= 6'd37;
            ov_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_START_SYMBOL)
                begin
                    start_reg <= cfg_data;
                end
                else
                begin
                    endcol_reg <= cfg_data[5:0];
                end
            end

            if (ov_set)
            begin
                ov_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                ov_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        tok_reg    <= token_type;
                        is_end_reg <= (cmd == CMD_END);
                        col_reg    <= (cmd == CMD_END) ? endcol_reg : token_type;
                        n_reg      <= '0;
                        if (cmd == CMD_START)
                        begin
                            sp_reg     <= SPW'(1);
                            failed_reg <= 1'b0;
                        end
                        else if ((cmd == CMD_TOKEN || cmd == CMD_END) && !failed_reg)
                        begin
                            state_reg <= S_TOP;
                        end
                    end
                end
                S_TOP:
                begin
                    if (sp_reg != '0)
                    begin
                        state_reg <= S_HAVE;
                    end
                    else if (slot_free)
                    begin
                        res_reg.kind       <= is_end_reg ? KIND_ACCEPT : KIND_TRAILING;
                        res_reg.production <= '0;
                        res_reg.symbol     <= is_end_reg ? 7'd0 : {1'b0, tok_reg};
                        res_reg.last       <= 1'b1;
                        failed_reg         <= !is_end_reg;
                        state_reg          <= S_IDLE;
                    end
                end
                S_HAVE:
                begin
                    if (top_is_term || n_reg == RESULT_LIMIT || lookup_bad)
                    begin
                        if (slot_free)
                        begin
                            res_reg.production <= '0;
                            res_reg.symbol     <= stk_rd;
                            res_reg.last       <= 1'b1;
                            state_reg          <= S_IDLE;
                            if (top_is_term)
                            begin
                                if (!is_end_reg && stk_rd == {1'b0, tok_reg})
                                begin
                                    res_reg.kind <= KIND_MATCH;
                                    sp_reg       <= sp_dec;
                                end
                                else
                                begin
                                    res_reg.kind <= KIND_MISMATCH;
                                    failed_reg   <= 1'b1;
                                end
                            end
                            else
                            begin
                                res_reg.kind <= (n_reg == RESULT_LIMIT) ? KIND_LIMIT
                                                                        : KIND_MISS;
                                failed_reg   <= 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        state_reg <= S_TBL;
                    end
                end
                S_TBL:
                begin
                    entry_reg <= tbl_rd;
                    if (entry_bad)
                    begin
                        if (slot_free)
                        begin
                            res_reg.kind       <= KIND_MISS;
                            res_reg.production <= '0;
                            res_reg.symbol     <= stk_rd;
                            res_reg.last       <= 1'b1;
                            failed_reg         <= 1'b1;
                            state_reg          <= S_IDLE;
                        end
                    end
                    else
                    begin
                        state_reg <= S_LEN;
                    end
                end
                S_LEN:
                begin
                    if (slot_free)
                    begin
                        res_reg.production <= entry_reg[6:0];
                        res_reg.symbol     <= stk_rd;
                        sp_reg             <= sp_dec;
                        if (overflow)
                        begin
                            res_reg.kind <= KIND_LIMIT;
                            res_reg.last <= 1'b1;
                            failed_reg   <= 1'b1;
                            state_reg    <= S_IDLE;
                        end
                        else
                        begin
                            res_reg.kind <= KIND_EXPAND;
                            res_reg.last <= 1'b0;
                            n_reg        <= n_reg + 6'd1;
                            cnt_reg      <= len_eff;
                            state_reg    <= (len_eff != '0) ? S_PUSH : S_TOP;
                        end
                    end
                end
                S_PUSH:
                begin
                    sp_reg  <= sp_reg + SPW'(1);
                    cnt_reg <= cnt_dec;
                    if (cnt_dec == '0)
                    begin
                        state_reg <= S_TOP;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = ov_reg;
    assign kind       = res_reg.kind;
    assign production = res_reg.production;
    assign symbol     = res_reg.symbol;
    assign last       = res_reg.last;

endmodule

FILE: src/ll1pp_checker.sv
module ll1pp_checker
    import ll1pp_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [2:0] kind,
    input logic [6:0] symbol,
    input logic       last
);

    // A stalled word stays offered.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output word dropped while stalled");

    // A stalled word keeps its contents.
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(kind) && $stable(symbol) && $stable(last))
        else $error("output word changed while stalled");

    // Only expansions may be followed by more words of the same item.
    a_not_last_is_expand: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> kind == KIND_EXPAND)
        else $error("non-final word is not an expansion");

    // An expansion never ends an item.
    a_expand_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_EXPAND |-> !last)
        else $error("expansion marked as final word");

endmodule

bind ll1_predictive_parser ll1pp_checker u_ll1pp_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .symbol(symbol), .last(last)
);

FILE: sim/ll1_predictive_parser_checker.sv
`timescale 1ns / 100ps

// Watches the three channels of the parser, keeps its own copy of the tables,
// the stack and the registers, and compares every result word with the oldest
// predicted one.
module ll1_predictive_parser_checker
    import ll1pp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [2:0]        cmd,
    input  logic [5:0]        table_row,
    input  logic [5:0]        table_col,
    input  logic signed [7:0] table_entry,
    input  logic [6:0]        prod_index,
    input  logic [2:0]        prod_pos,
    input  logic signed [7:0] prod_symbol,
    input  logic [3:0]        prod_length,
    input  logic [5:0]        token_type,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic [2:0]        kind,
    input  logic [6:0]        production,
    input  logic [6:0]        symbol,
    input  logic              last,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [6:0]        cfg_data,
    output int                mismatches,
    output int                outstanding
);

    localparam int N_TERM    = 38;
    localparam int N_NONTERM = 64;
    localparam int N_PROD    = 128;
    localparam int RHS_MAX   = 8;
    localparam int DEPTH     = 256;

    // Shadow copies of the parser state.
    logic [7:0] cell_mem [N_NONTERM * N_TERM];
    logic [7:0] rhs_mem [N_PROD * RHS_MAX];
    logic [3:0] rhs_len [N_PROD];
    logic [6:0] stack_mem [DEPTH];
    int         depth_q;
    bit         broken;
    logic [6:0] start_sym;
    logic [5:0] end_col;

    // Predicted result words, oldest first.
    result_t    trace_q[$];
    int         word_results;

    function automatic void post(logic [2:0] k, logic [6:0] p, logic [6:0] s, logic l);
        trace_q.insert(trace_q.size(), result_t'{k, p, s, l});
        word_results++;
    endfunction

    // Expand nonterminals on top of the stack until a terminal shows up, the
    // stack runs empty, or an error is reported. Returns 0 after an error.
    function automatic bit walk_down(int col);
        int top;
        int row;
        int entry;
        int len;
        while (depth_q > 0)
        begin
            top = stack_mem[depth_q - 1];
            if (top < N_TERM)
                return 1'b1;
            row = top - N_TERM;
            if (word_results >= RESULT_LIMIT)
            begin
                post(KIND_LIMIT, 7'd0, 7'(top), 1'b1);
                broken = 1'b1;
                return 1'b0;
            end
            if (row >= N_NONTERM || col >= N_TERM || cell_mem[row * N_TERM + col][7])
            begin
                post(KIND_MISS, 7'd0, 7'(top), 1'b1);
                broken = 1'b1;
                return 1'b0;
            end
            entry = cell_mem[row * N_TERM + col];
            len = rhs_len[entry];
            if (len > RHS_MAX)
                len = RHS_MAX;
            if (rhs_mem[entry * RHS_MAX] == EPSILON_SYMBOL)
                len = 0;
            depth_q--;
            if (depth_q + len > DEPTH)
            begin
                post(KIND_LIMIT, 7'(entry), 7'(top), 1'b1);
                broken = 1'b1;
                return 1'b0;
            end
            post(KIND_EXPAND, 7'(entry), 7'(top), 1'b0);
            // The right side goes on in reverse so its first symbol ends on top.
            while (len > 0)
            begin
                len--;
                stack_mem[depth_q] = rhs_mem[entry * RHS_MAX + len][6:0];
                depth_q++;
            end
        end
        return 1'b1;
    endfunction

    // Apply one accepted input word to the shadow state.
    function automatic void take_word();
        case (cmd)
            CMD_TABLE_WR:
                if (table_col < N_TERM)
                    cell_mem[table_row * N_TERM + table_col] = table_entry;
            CMD_PROD_WR:
            begin
                rhs_mem[prod_index * RHS_MAX + prod_pos] = prod_symbol;
                rhs_len[prod_index] = prod_length;
            end
            CMD_START:
            begin
                broken = 1'b0;
                stack_mem[0] = start_sym;
                depth_q = 1;
            end
            CMD_TOKEN:
                if (!broken)
                begin
                    word_results = 0;
                    if (walk_down(token_type))
                    begin
                        if (depth_q == 0)
                        begin
                            post(KIND_TRAILING, 7'd0, 7'(token_type), 1'b1);
                            broken = 1'b1;
                        end
                        else if (stack_mem[depth_q - 1] == token_type)
                        begin
                            depth_q--;
                            post(KIND_MATCH, 7'd0, 7'(token_type), 1'b1);
                        end
                        else
                        begin
                            post(KIND_MISMATCH, 7'd0, stack_mem[depth_q - 1], 1'b1);
                            broken = 1'b1;
                        end
                    end
                end
            CMD_END:
                if (!broken)
                begin
                    word_results = 0;
                    if (walk_down(end_col))
                    begin
                        if (depth_q == 0)
                            post(KIND_ACCEPT, 7'd0, 7'd0, 1'b1);
                        else
                        begin
                            post(KIND_MISMATCH, 7'd0, stack_mem[depth_q - 1], 1'b1);
                            broken = 1'b1;
                        end
                    end
                end
            default: ;
        endcase
    endfunction

    // Result words are checked before the input word of the same edge is applied.
    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            depth_q = 0;
            broken = 1'b0;
            start_sym = 7'd38;
            end_col = 6'd37;
            trace_q.delete();
            mismatches = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = result_t'{kind, production, symbol, last};
                if (trace_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: unexpected result word kind %0d prod %0d sym %0d last %0d",
                                 $realtime, kind, production, symbol, last);
                    mismatches++;
                end
                else
                begin
                    want = trace_q.pop_front();
                    if (got.kind !== want.kind || got.production !== want.production ||
                        got.symbol !== want.symbol || got.last !== want.last)
                    begin
                        if (mismatches < 10)
                            $display({"%0t: result mismatch: expected kind %0d prod %0d sym %0d ",
                                      "last %0d, got kind %0d prod %0d sym %0d last %0d"},
                                     $realtime, want.kind, want.production, want.symbol,
                                     want.last, got.kind, got.production, got.symbol, got.last);
                        mismatches++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_START_SYMBOL)
                    start_sym = cfg_data;
                else
                    end_col = cfg_data[5:0];
            end
            if (in_valid && !in_stall)
                take_word();
        end
        outstanding = trace_q.size();
    end

endmodule

FILE: sim/ll1_predictive_parser_test.sv
`timescale 1ns / 100ps

module ll1_predictive_parser_test;
    import ll1pp_pkg::*;

    localparam int STALL_LIMIT = 3000;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [2:0]        cmd;
    logic [5:0]        table_row;
    logic [5:0]        table_col;
    logic signed [7:0] table_entry;
    logic [6:0]        prod_index;
    logic [2:0]        prod_pos;
    logic signed [7:0] prod_symbol;
    logic [3:0]        prod_length;
    logic [5:0]        token_type;
    logic              out_valid;
    logic              out_stall;
    logic [2:0]        kind;
    logic [6:0]        production;
    logic [6:0]        symbol;
    logic              last;
    logic              cfg_valid;
    logic              cfg_ready;
    logic              cfg_index;
    logic [6:0]        cfg_data;

    int  mismatches;
    int  outstanding;
    int  words_sent;
    int  idle_cycles;
    bit  calm;
    bit  squeeze_req;

    ll1_predictive_parser dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .table_row(table_row), .table_col(table_col),
        .table_entry(table_entry), .prod_index(prod_index), .prod_pos(prod_pos),
        .prod_symbol(prod_symbol), .prod_length(prod_length), .token_type(token_type),
        .out_valid(out_valid), .out_stall(out_stall),
        .kind(kind), .production(production), .symbol(symbol), .last(last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    ll1_predictive_parser_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .table_row(table_row), .table_col(table_col),
        .table_entry(table_entry), .prod_index(prod_index), .prod_pos(prod_pos),
        .prod_symbol(prod_symbol), .prod_length(prod_length), .token_type(token_type),
        .out_valid(out_valid), .out_stall(out_stall),
        .kind(kind), .production(production), .symbol(symbol), .last(last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .mismatches(mismatches), .outstanding(outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one, none while calm.
    function automatic int idle_len();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Receiver: random stalls, plus one long hold-off when asked for.
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (squeeze_req)
            begin
                squeeze_req = 1'b0;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                if ($urandom_range(0, 3) == 0)
                    hold_left = idle_len();
            end
        end
    end

    // Watchdog on cycles with no handshake on any channel.
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Offer one input word and hold it until it is taken.
    task automatic put_word(int c, int r, int col, int e, int pi, int pp, int ps, int pl,
                            int tk);
        int gap;
        gap = idle_len();
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        cmd <= 3'(c);
        table_row <= 6'(r);
        table_col <= 6'(col);
        table_entry <= 8'(e);
        prod_index <= 7'(pi);
        prod_pos <= 3'(pp);
        prod_symbol <= 8'(ps);
        prod_length <= 4'(pl);
        token_type <= 6'(tk);
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        words_sent++;
    endtask

    task automatic write_cell(int r, int c, int e);
        put_word(CMD_TABLE_WR, r, c, e, $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic write_rhs(int p, int pos, int s, int l);
        put_word(CMD_PROD_WR, $urandom, $urandom, $urandom, p, pos, s, l, $urandom);
    endtask

    task automatic send_cmd(int c, int tk);
        put_word(c, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, tk);
    endtask

    task automatic write_reg(logic idx, int value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= 7'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Drain all results and let the walk come to rest.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (outstanding == 0);
        repeat (60) @(posedge clk);
    endtask

    // Grammar on start symbol 38 (row 0): token 1 gives "1 S", token 2 gives
    // "2 S", the end marker gives epsilon. Token 3 hits a negative entry,
    // token 4 an empty right side stored with length zero, token 5 an entry
    // above the production range. Row 1 on token 1 gives "1 2", row 2 recurses
    // on itself, row 3 pushes eight copies of itself with a length of fifteen.
    task automatic load_grammar();
        write_rhs(0, 0, 1, 2);
        write_rhs(0, 1, 38, 2);
        write_rhs(1, 0, 2, 2);
        write_rhs(1, 1, 38 + 128, 2);
        write_rhs(2, 0, 255, 1);
        write_rhs(3, 0, 1, 2);
        write_rhs(3, 1, 2, 2);
        write_rhs(4, 0, 40, 1);
        for (int pos = 0; pos < 8; pos++)
            write_rhs(5, pos, 41, 15);
        write_rhs(6, 0, 5, 0);
        write_cell(0, 1, 0);
        write_cell(0, 2, 1);
        write_cell(0, 37, 2);
        write_cell(0, 3, 255);
        write_cell(0, 4, 6);
        write_cell(0, 5, 200);
        write_cell(1, 1, 3);
        write_cell(2, 1, 4);
        write_cell(3, 1, 5);
    endtask

    // Mostly tokens that parse, now and then one that fails.
    function automatic int pick_token();
        int x;
        x = $urandom_range(0, 9);
        if (x < 4)
            return 1;
        if (x < 8)
            return 2;
        if (x == 8)
            return $urandom_range(3, 5);
        return ($urandom_range(0, 1) != 0) ? 40 : 37;
    endfunction

    // One sentence: start, some tokens, end. A few are broken on purpose.
    task automatic parse_run(int max_tokens);
        bit spoil;
        int n;
        spoil = ($urandom_range(0, 99) < 15);
        if (!spoil || $urandom_range(0, 1))
            send_cmd(CMD_START, $urandom);
        n = $urandom_range(1, max_tokens);
        for (int i = 0; i < n; i++)
        begin
            if (spoil && $urandom_range(0, 3) == 0)
                send_cmd($urandom_range(5, 7), $urandom);
            else
                send_cmd(CMD_TOKEN, pick_token());
        end
        if (!spoil || $urandom_range(0, 1))
            send_cmd(CMD_END, $urandom);
        if ($urandom_range(0, 4) == 0)
            calm = ~calm;
    endtask

    // Stimulus and verdict.
    initial
    begin
        int base;
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = CMD_TABLE_WR;
        table_row = '0;
        table_col = '0;
        table_entry = '0;
        prod_index = '0;
        prod_pos = '0;
        prod_symbol = '0;
        prod_length = '0;
        token_type = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_START_SYMBOL;
        cfg_data = '0;
        words_sent = 0;
        calm = 1'b1;
        squeeze_req = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_reg(CFG_START_SYMBOL, 38);
        write_reg(CFG_END_COLUMN, 37);
        load_grammar();
        calm = 1'b0;

        // Ignored commands and an ignored write, accept, trailing input and misses.
        send_cmd(3'd5, $urandom);
        send_cmd(3'd6, $urandom);
        send_cmd(3'd7, $urandom);
        write_cell(1, 40, $urandom);
        send_cmd(CMD_START, 0);
        send_cmd(CMD_TOKEN, 1);
        send_cmd(CMD_TOKEN, 2);
        send_cmd(CMD_TOKEN, 1);
        send_cmd(CMD_END, 0);
        send_cmd(CMD_END, 0);
        send_cmd(CMD_TOKEN, 1);
        send_cmd(CMD_TOKEN, 1);
        send_cmd(CMD_END, 0);
        send_cmd(CMD_START, 0);
        send_cmd(CMD_TOKEN, 3);
        send_cmd(CMD_START, 0);
        send_cmd(CMD_TOKEN, 5);
        send_cmd(CMD_START, 0);
        send_cmd(CMD_TOKEN, 40);
        send_cmd(CMD_START, 0);
        send_cmd(CMD_TOKEN, 4);
        send_cmd(CMD_START, 0);
        send_cmd(CMD_TOKEN, 1);
        send_cmd(CMD_START, 0);
        send_cmd(CMD_TOKEN, 2);
        send_cmd(CMD_END, 0);
        settle();

        // Terminal left at end of input, a full match, and a token mismatch.
        write_reg(CFG_START_SYMBOL, 39);
        send_cmd(CMD_START, 0);
        send_cmd(CMD_TOKEN, 1);
        send_cmd(CMD_END, 0);
        send_cmd(CMD_START, 0);
        send_cmd(CMD_TOKEN, 1);
        send_cmd(CMD_TOKEN, 2);
        send_cmd(CMD_END, 0);
        send_cmd(CMD_START, 0);
        send_cmd(CMD_TOKEN, 1);
        send_cmd(CMD_TOKEN, 3);
        settle();

        // Endless recursion runs into the result limit, a wide right side
        // overflows the stack, and a symbol beyond the last row misses.
        write_reg(CFG_START_SYMBOL, 40);
        send_cmd(CMD_START, 0);
        send_cmd(CMD_TOKEN, 1);
        settle();
        write_reg(CFG_START_SYMBOL, 41);
        send_cmd(CMD_START, 0);
        send_cmd(CMD_TOKEN, 1);
        settle();
        write_reg(CFG_START_SYMBOL, 127);
        send_cmd(CMD_START, 0);
        send_cmd(CMD_TOKEN, 1);
        settle();

        // Moved end marker, random sentences, long receiver hold.
        write_reg(CFG_START_SYMBOL, 38);
        write_reg(CFG_END_COLUMN, 6);
        write_cell(0, 6, 2);
        squeeze_req = 1'b1;
        base = words_sent;
        while (words_sent - base < 40)
            parse_run(6);
        settle();

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: ll1_predictive_parser.f
src/ll1pp_pkg.sv
src/ll1pp_ram.sv
src/ll1_predictive_parser.sv
src/ll1pp_checker.sv
sim/ll1_predictive_parser_checker.sv
sim/ll1_predictive_parser_test.sv
